// ----- sv/canonical_huffman_decoder_defines.svh -----
// ----------------------------------------------------------------------------
// Canonical Huffman decoder assertion macros
// Shared property wrappers for the checks at the end of the decoder.
// ----------------------------------------------------------------------------
`ifndef CANONICAL_HUFFMAN_DECODER_DEFINES_SVH
`define CANONICAL_HUFFMAN_DECODER_DEFINES_SVH

// Clocked check, suspended while reset is asserted.
`define CHD_ASSERT(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked check that is also evaluated during reset.
`define CHD_ASSERT_ALWAYS(label, clk, prop, msg) \
	label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- sv/chd_pkg.sv -----
// ----------------------------------------------------------------------------
// Canonical Huffman decoder package
// Payload types, operation and result codes, and default parameter values.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
package chd_pkg;

	localparam int MAX_LEN_DEF  = 15;
	localparam int ALPHABET_DEF = 256;

	// Operation codes of an input request.
	localparam logic [1:0] OP_LOAD  = 2'd0;
	localparam logic [1:0] OP_BUILD = 2'd1;
	localparam logic [1:0] OP_DATA  = 2'd2;

	// Result kinds.
	localparam logic [1:0] KIND_SYMBOL = 2'd0;
	localparam logic [1:0] KIND_READY  = 2'd1;
	localparam logic [1:0] KIND_ERROR  = 2'd2;

	typedef struct packed {
		logic [1:0] op;
		logic [7:0] symbol_index;
		logic [3:0] code_length;
		logic [7:0] data_byte;
		logic [3:0] valid_bits;
	} in_t;

	typedef struct packed {
		logic [1:0]  kind;
		logic [7:0]  symbol;
		logic [31:0] decoded_count;
		logic        last;
	} out_t;

	// Write request into the code length store.
	typedef struct packed {
		logic       en;
		logic [7:0] addr;
		logic [3:0] len;
	} len_wr_t;

endpackage
`default_nettype wire

// ----- sv/chd_chan_if.sv -----
// ----------------------------------------------------------------------------
// Canonical Huffman decoder channel
// Valid/ready channel carrying one payload of a configurable type.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
interface chd_chan_if #(
	parameter type payload_t = logic
);
	logic     valid;
	logic     ready;
	payload_t payload;

	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface
`default_nettype wire

// ----- sv/chd_len_store.sv -----
// ----------------------------------------------------------------------------
// Code length store
// Synchronous memory of per-symbol code lengths with reset-cleared valid bits.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module chd_len_store #(
	parameter int ALPHABET = chd_pkg::ALPHABET_DEF
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire chd_pkg::len_wr_t  wr,
	input  wire logic [$clog2(ALPHABET)-1:0] rd_addr,
	output logic [3:0]             rd_len
);
	import chd_pkg::*;

	localparam int AW = $clog2(ALPHABET);

	logic [3:0]          mem [0:ALPHABET-1];
	logic [ALPHABET-1:0] valid_q;
	logic [3:0]          rd_data_q;
	logic                rd_valid_q;

	// Memory write and registered read.
	always_ff @(posedge clk) begin
		if (wr.en) begin
			mem[wr.addr[AW-1:0]] <= wr.len;
		end
		rd_data_q <= mem[rd_addr];
	end

	// An entry never loaded since reset reads as length zero.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q    <= '0;
			rd_valid_q <= 1'b0;
		end else begin
			if (wr.en) begin
				valid_q[wr.addr[AW-1:0]] <= 1'b1;
			end
			rd_valid_q <= valid_q[rd_addr];
		end
	end

	assign rd_len = rd_valid_q ? rd_data_q : 4'd0;
endmodule
`default_nettype wire

// ----- sv/canonical_huffman_decoder.sv -----
// ----------------------------------------------------------------------------
// Canonical Huffman decoder
// Loads code lengths, builds canonical tables and decodes a bit stream.
// ----------------------------------------------------------------------------
// One request is handled at a time. A load request writes the length store as
// it is accepted. A build sweeps the length memory twice and walks the lengths
// once, and ends with a ready result. A data byte is decoded one code bit at a
// time, with one more step per decoded symbol for the sorted symbol memory
// read, and passes through entry and exit states; each result waits for the
// output register to drain. A symbol limit that has been reached stops the
// bit loop at once.
`timescale 1ns / 1ps
`default_nettype none
`include "canonical_huffman_decoder_defines.svh"
module canonical_huffman_decoder #(
	parameter int MAX_LEN  = chd_pkg::MAX_LEN_DEF,
	parameter int ALPHABET = chd_pkg::ALPHABET_DEF
) (
	input wire logic clk,
	input wire logic arst_n,
	chd_chan_if.sink   din,
	chd_chan_if.source dout,
	chd_chan_if.sink   cfg
);
	import chd_pkg::*;

	localparam int AW  = $clog2(ALPHABET);
	localparam int LW  = $clog2(MAX_LEN + 1);
	localparam int FCW = MAX_LEN + 10;

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_CNT  = 3'd1;
	localparam logic [2:0] S_FC   = 3'd2;
	localparam logic [2:0] S_SORT = 3'd3;
	localparam logic [2:0] S_BIT  = 3'd4;
	localparam logic [2:0] S_SYM  = 3'd5;
	localparam logic [2:0] S_FIN  = 3'd6;

	logic [2:0]  state_q;
	logic [31:0] limit_q;

	// Per-length tables.
	logic [8:0]     cnt_q   [0:MAX_LEN];
	logic [FCW-1:0] first_q [0:MAX_LEN];
	logic [8:0]     off_q   [0:MAX_LEN];
	logic [8:0]     pos_q   [0:MAX_LEN];

	// Build sequencing.
	logic [AW:0]    sw_q;
	logic           v_s1;
	logic [AW-1:0]  sym_s1;
	logic [LW-1:0]  k_q;
	logic [FCW-1:0] code_q;
	logic [8:0]     offacc_q;

	// Stream state.
	logic [MAX_LEN-1:0] pc_q;
	logic [LW-1:0]      pl_q;
	logic [31:0]        emit_q;
	logic               halted_q;
	logic [7:0]         byte_q;
	logic [3:0]         nb_q;
	logic [3:0]         bi_q;

	// Pending result and output register.
	logic       pend_v_q;
	out_t       pend_q;
	logic       out_v_q;
	out_t       out_q;

	// Length store and sorted symbol memory.
	len_wr_t       lwr;
	logic [3:0]    rd_len;
	logic [7:0]    smem [0:ALPHABET-1];
	logic [7:0]    smem_rd_q;
	logic          s_we;
	logic [AW-1:0] s_waddr;
	logic [AW-1:0] s_raddr;

	// Decode step for the next bit.
	logic               bit_in;
	logic [MAX_LEN-1:0] pc_n;
	logic [LW-1:0]      pl_n;
	logic [FCW-1:0]     pcx;
	logic [FCW-1:0]     diff;
	logic               hit;
	logic               len_ok;
	logic [LW-1:0]      len_idx;
	logic               issue;

	chd_len_store #(.ALPHABET(ALPHABET)) u_len (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr      (lwr),
		.rd_addr (sw_q[AW-1:0]),
		.rd_len  (rd_len)
	);

	// Load requests write the length store directly.
	always_comb begin
		lwr.en   = din.valid && din.ready && (din.payload.op == OP_LOAD) &&
			({1'b0, din.payload.symbol_index} < 9'(ALPHABET));
		lwr.addr = din.payload.symbol_index;
		lwr.len  = din.payload.code_length;
	end

	// Combinational decode of one bit.
	always_comb begin
		bit_in = byte_q[7];
		pc_n   = {pc_q[MAX_LEN-2:0], bit_in};
		pl_n   = pl_q + LW'(1);
		pcx    = FCW'(pc_n);
		diff   = pcx - first_q[pl_n];
		hit    = (pcx >= first_q[pl_n]) && (diff < FCW'(cnt_q[pl_n]));
		s_raddr = AW'(off_q[pl_n] + diff[8:0]);
	end

	// Length read back during the build sweeps.
	assign len_ok  = (rd_len != 4'd0) && (5'(rd_len) <= 5'(MAX_LEN));
	assign len_idx = LW'(rd_len);
	assign issue   = ((state_q == S_CNT) || (state_q == S_SORT)) &&
		(sw_q < (AW+1)'(ALPHABET));
	assign s_we    = (state_q == S_SORT) && v_s1 && len_ok;
	assign s_waddr = pos_q[len_idx][AW-1:0];

	// Sorted symbol memory.
	always_ff @(posedge clk) begin
		if (s_we) begin
			smem[s_waddr] <= 8'(sym_s1);
		end
		smem_rd_q <= smem[s_raddr];
	end

	assign din.ready    = (state_q == S_IDLE);
	assign cfg.ready    = 1'b1;
	assign dout.valid   = out_v_q;
	assign dout.payload = out_q;

	// Main sequencer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			limit_q  <= '0;
			for (int i = 0; i <= MAX_LEN; i++) begin
				cnt_q[i]   <= '0;
				first_q[i] <= '0;
				off_q[i]   <= '0;
				pos_q[i]   <= '0;
			end
			sw_q     <= '0;
			v_s1     <= 1'b0;
			sym_s1   <= '0;
			k_q      <= '0;
			code_q   <= '0;
			offacc_q <= '0;
			pc_q     <= '0;
			pl_q     <= '0;
			emit_q   <= '0;
			halted_q <= 1'b0;
			byte_q   <= '0;
			nb_q     <= '0;
			bi_q     <= '0;
			pend_v_q <= 1'b0;
			pend_q   <= '0;
			out_v_q  <= 1'b0;
			out_q    <= '0;
		end else begin
			if (cfg.valid) begin
				limit_q <= cfg.payload;
			end
			if (out_v_q && dout.ready) begin
				out_v_q <= 1'b0;
			end
			v_s1   <= issue;
			sym_s1 <= sw_q[AW-1:0];
			if (issue) begin
				sw_q <= sw_q + (AW+1)'(1);
			end

			unique case (state_q)
				S_IDLE: begin
					if (din.valid) begin
						case (din.payload.op)
							OP_BUILD: begin
								for (int i = 0; i <= MAX_LEN; i++) begin
									cnt_q[i]   <= '0;
									first_q[i] <= '0;
									off_q[i]   <= '0;
								end
								pc_q     <= '0;
								pl_q     <= '0;
								emit_q   <= '0;
								halted_q <= 1'b0;
								sw_q     <= '0;
								state_q  <= S_CNT;
							end
							OP_DATA: begin
								if (!halted_q) begin
									byte_q  <= din.payload.data_byte;
									nb_q    <= (din.payload.valid_bits > 4'd8) ? 4'd8 :
										din.payload.valid_bits;
									bi_q    <= '0;
									state_q <= S_BIT;
								end
							end
							default: begin
							end
						endcase
					end
				end
				S_CNT: begin
					if (v_s1 && len_ok) begin
						cnt_q[len_idx] <= cnt_q[len_idx] + 9'd1;
					end
					if (!issue && !v_s1) begin
						k_q      <= LW'(1);
						code_q   <= '0;
						offacc_q <= '0;
						state_q  <= S_FC;
					end
				end
				S_FC: begin
					// One length per cycle: first code and sorted offset.
					first_q[k_q] <= (code_q + FCW'(cnt_q[k_q - LW'(1)])) << 1;
					code_q       <= (code_q + FCW'(cnt_q[k_q - LW'(1)])) << 1;
					off_q[k_q]   <= offacc_q;
					pos_q[k_q]   <= offacc_q;
					offacc_q     <= offacc_q + cnt_q[k_q];
					if (k_q == LW'(MAX_LEN)) begin
						sw_q    <= '0;
						state_q <= S_SORT;
					end else begin
						k_q <= k_q + LW'(1);
					end
				end
				S_SORT: begin
					if (s_we) begin
						pos_q[len_idx] <= pos_q[len_idx] + 9'd1;
					end
					if (!issue && !v_s1) begin
						pend_v_q <= 1'b1;
						pend_q   <= '{kind: KIND_READY, symbol: 8'd0,
							decoded_count: 32'd0, last: 1'b0};
						state_q  <= S_FIN;
					end
				end
				S_BIT: begin
					if ((bi_q == nb_q) || (emit_q >= limit_q)) begin
						state_q <= S_FIN;
					end else if (!pend_v_q || !out_v_q) begin
						byte_q <= byte_q << 1;
						bi_q   <= bi_q + 4'd1;
						if (pend_v_q && (hit || (pl_n == LW'(MAX_LEN)))) begin
							out_v_q <= 1'b1;
							out_q   <= pend_q;
						end
						if (hit) begin
							emit_q   <= emit_q + 32'd1;
							pend_v_q <= 1'b1;
							pend_q   <= '{kind: KIND_SYMBOL, symbol: 8'd0,
								decoded_count: emit_q + 32'd1, last: 1'b0};
							pc_q     <= '0;
							pl_q     <= '0;
							state_q  <= S_SYM;
						end else if (pl_n == LW'(MAX_LEN)) begin
							pend_v_q <= 1'b1;
							pend_q   <= '{kind: KIND_ERROR, symbol: 8'd0,
								decoded_count: emit_q, last: 1'b0};
							halted_q <= 1'b1;
							state_q  <= S_FIN;
						end else begin
							pc_q <= pc_n;
							pl_q <= pl_n;
						end
					end
				end
				S_SYM: begin
					pend_q.symbol <= smem_rd_q;
					state_q       <= S_BIT;
				end
				S_FIN: begin
					// The last result of the request carries the last flag.
					if (!out_v_q) begin
						if (pend_v_q) begin
							out_v_q  <= 1'b1;
							out_q    <= '{kind: pend_q.kind, symbol: pend_q.symbol,
								decoded_count: pend_q.decoded_count, last: 1'b1};
							pend_v_q <= 1'b0;
						end
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Checks on the sequencer.
	`CHD_ASSERT(a_idle_no_pend, clk, arst_n, din.ready |-> !pend_v_q, "pending result left in idle")
	`CHD_ASSERT(a_pl_range, clk, arst_n, pl_q < LW'(MAX_LEN), "partial code length out of range")
	`CHD_ASSERT_ALWAYS(a_halt_no_bit, clk, halted_q |-> (state_q != S_BIT && state_q != S_SYM), "decoding while halted")
endmodule
`default_nettype wire
